/* hdl/dense_layer_with_activation_macros.svh */
// Assertion macros for the dense layer block.
// No dependencies; included by the top level.
`ifndef DENSE_LAYER_WITH_ACTIVATION_MACROS_SVH
`define DENSE_LAYER_WITH_ACTIVATION_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DLA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on every edge, reset included.
`define DLA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hdl/dla_pkg.sv */
// Package for the dense layer block: payload types, codes, sigmoid table.
// No dependencies.
package dla_pkg;
    localparam int MAX_INPUTS  = 64;
    localparam int MAX_NEURONS = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_MODE    = 2'd0,
        CFG_INPUTS  = 2'd1,
        CFG_NEURONS = 2'd2,
        CFG_UNUSED  = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] ACT_RELU = 2'd1;
    localparam logic [1:0] ACT_SIG  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         neuron_index;
        logic [5:0]         input_index;
        logic signed [15:0] value;
    } t_in_word;

    typedef struct packed {
        logic [3:0]         out_neuron;
        logic signed [15:0] activation;
        logic               last;
    } t_out_word;

    // Classified command from the front part.
    typedef struct packed {
        logic               start;   // sample store that completes the input set
        logic [1:0]         op;
        logic [3:0]         nidx;
        logic [5:0]         iidx;
        logic signed [15:0] value;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIAS,
        ST_MAC,
        ST_DRAIN,
        ST_POST,
        ST_EMIT
    } t_state;

    function automatic logic [8:0] sig_half(input logic [6:0] k);
        logic [8:0] t [0:127];
        t = '{
            128, 132, 136, 140, 144, 148, 152, 156, 159, 163, 167, 170, 174, 177, 181, 184,
            187, 190, 193, 196, 199, 202, 204, 207, 209, 212, 214, 216, 218, 220, 222, 224,
            225, 227, 229, 230, 232, 233, 234, 235, 237, 238, 239, 240, 241, 241, 242, 243,
            244, 245, 245, 246, 246, 247, 248, 248, 248, 249, 249, 250, 250, 250, 251, 251,
            251, 252, 252, 252, 252, 253, 253, 253, 253, 253, 254, 254, 254, 254, 254, 254,
            254, 254, 254, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255, 255,
            255, 255, 255, 255, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256,
            256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256, 256
        };
        return t[k];
    endfunction
endpackage

/* hdl/dla_front.sv */
// Front part: accepts input words, filters invalid ones, flags the start.
// Depends on dla_pkg.
module dla_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dla_pkg::t_in_word i_word,
    input  logic [5:0]        i_last_idx,
    output logic              o_push,
    output dla_pkg::t_cmd     o_cmd,
    input  logic              i_full
);
    logic r_vld;
    dla_pkg::t_cmd r_cmd;
    dla_pkg::t_cmd n_cmd;
    logic n_keep;

    assign o_ready = !r_vld || !i_full;
    assign o_push  = r_vld && !i_full;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_cmd.op    = i_word.operation;
        n_cmd.nidx  = i_word.neuron_index;
        n_cmd.iidx  = i_word.input_index;
        n_cmd.value = i_word.value;
        n_cmd.start = (i_word.operation == dla_pkg::OP_SAMPLE) &&
                      (i_word.input_index == i_last_idx);
        n_keep = (i_word.operation != dla_pkg::OP_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid && n_keep;
        end
        if (o_ready) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

/* hdl/dla_queue.sv */
// Short command queue between front and back parts.
// Depends on dla_pkg.
module dla_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dla_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output dla_pkg::t_cmd o_cmd
);
    localparam int AW = $clog2(dla_pkg::QUEUE_DEPTH);
    dla_pkg::t_cmd r_mem [0:dla_pkg::QUEUE_DEPTH-1];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(dla_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_cmd;
    end
endmodule

/* hdl/dla_back.sv */
// Back part: stores, one MAC shared by all neurons, activation, result register.
// Depends on dla_pkg.
module dla_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  dla_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    input  logic [1:0]         i_mode,
    input  logic [5:0]         i_last_idx,
    input  logic [3:0]         i_last_neu,
    output logic               o_valid,
    input  logic               i_ready,
    output dla_pkg::t_out_word o_word,
    output logic               o_busy
);
    logic signed [15:0] r_wmem [0:1023];
    logic signed [15:0] r_bmem [0:15];
    logic signed [15:0] r_smem [0:63];

    dla_pkg::t_state r_st, n_st;
    logic [3:0] r_n;
    logic [5:0] r_i;
    logic signed [15:0] r_w, r_s, r_b;
    logic signed [31:0] r_p;
    logic signed [39:0] r_acc;
    logic r_pv, r_rv;
    logic signed [15:0] r_x;
    logic r_ov;
    dla_pkg::t_out_word r_out;

    logic cmd_take, mac_rd, acc_clr;
    logic signed [39:0] q;
    logic signed [15:0] sat, act;
    logic signed [11:0] cl;
    logic [7:0] sidx;

    always_comb begin
        n_st = r_st;
        case (r_st)
            dla_pkg::ST_IDLE:  if (!i_empty && i_cmd.start) n_st = dla_pkg::ST_BIAS;
            dla_pkg::ST_BIAS:  n_st = dla_pkg::ST_MAC;
            dla_pkg::ST_MAC:   if (r_i == i_last_idx) n_st = dla_pkg::ST_DRAIN;
            dla_pkg::ST_DRAIN: if (!r_rv && !r_pv) n_st = dla_pkg::ST_POST;
            dla_pkg::ST_POST:  n_st = dla_pkg::ST_EMIT;
            dla_pkg::ST_EMIT:  if (!r_ov || i_ready) begin
                n_st = (r_n == i_last_neu) ? dla_pkg::ST_IDLE : dla_pkg::ST_BIAS;
            end
            default:           n_st = dla_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_take = (r_st == dla_pkg::ST_IDLE) && !i_empty;
        mac_rd   = (r_st == dla_pkg::ST_MAC);
        acc_clr  = (r_st == dla_pkg::ST_BIAS);
        o_pop    = cmd_take;
        o_busy   = (r_st != dla_pkg::ST_IDLE) || r_ov || !i_empty;
    end

    // floor shift by 8 then saturate, then activation
    always_comb begin
        q   = r_acc >>> 8;
        if (q > 40'sd32767)       sat = 16'sh7fff;
        else if (q < -40'sd32768) sat = 16'sh8000;
        else                      sat = q[15:0];
        if (r_x < -16'sd2048)     cl = -12'sd2048;
        else if (r_x > 16'sd2047) cl = 12'sd2047;
        else                      cl = r_x[11:0];
        sidx = 8'(cl[11:4] + 8'd128);
        case (i_mode)
            dla_pkg::ACT_RELU: act = r_x[15] ? 16'sd0 : r_x;
            dla_pkg::ACT_SIG: begin
                if (sidx[7])          act = 16'(dla_pkg::sig_half(sidx[6:0]));
                else if (sidx == '0)  act = 16'sd0;
                else                  act = 16'(9'd256 - dla_pkg::sig_half(7'(8'd128 - sidx)));
            end
            default:           act = r_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= dla_pkg::ST_IDLE;
            r_rv <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
            r_n  <= '0;
            r_i  <= '0;
        end else begin
            r_st <= n_st;
            r_rv <= mac_rd;
            r_pv <= r_rv;
            if (r_st == dla_pkg::ST_EMIT && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
                r_n  <= (r_n == i_last_neu) ? 4'd0 : r_n + 4'd1;
            end else if (o_valid && i_ready) begin
                r_ov <= 1'b0;
            end
            if (r_st == dla_pkg::ST_BIAS) r_i <= '0;
            else if (mac_rd)              r_i <= r_i + 6'd1;
        end
        if (cmd_take) begin
            case (dla_pkg::t_op'(i_cmd.op))
                dla_pkg::OP_WEIGHT: r_wmem[{i_cmd.nidx, i_cmd.iidx}] <= i_cmd.value;
                dla_pkg::OP_BIAS:   r_bmem[i_cmd.nidx] <= i_cmd.value;
                dla_pkg::OP_SAMPLE: r_smem[i_cmd.iidx] <= i_cmd.value;
                default: ;
            endcase
        end
        r_w <= r_wmem[{r_n, r_i}];
        r_s <= r_smem[r_i];
        r_b <= r_bmem[r_n];
        r_p <= r_w * r_s;
        // bias seeds the sum on the first MAC cycle; products arrive through the r_w/r_s and r_p registers
        if (acc_clr)                                   r_acc <= '0;
        else if (r_st == dla_pkg::ST_MAC && r_i == '0) r_acc <= 40'(r_b) <<< 8;
        else if (r_pv)                                 r_acc <= r_acc + 40'(r_p);
        if (r_st == dla_pkg::ST_POST) r_x <= sat;
        if (r_st == dla_pkg::ST_EMIT && (!r_ov || i_ready)) begin
            r_out.out_neuron <= r_n;
            r_out.activation <= act;
            r_out.last       <= (r_n == i_last_neu);
        end
    end

    assign o_valid = r_ov;
    assign o_word  = r_out;
endmodule

/* hdl/dense_layer_with_activation.sv */
// Top level of the dense layer block: config registers, front, queue, back.
// Depends on dla_pkg, dla_front, dla_queue, dla_back and the macros header.
//
// Usage: words enter on i_valid/o_ready as dla_pkg::t_in_word. A word
// writes a weight, writes a bias or stores a sample. Storing the sample at
// index input_count-1 starts an evaluation; the block then emits one word
// per neuron on o_valid/i_ready as dla_pkg::t_out_word, last marks the end.
// Store words pass through the front register and the two-entry queue.
// An evaluation runs one shared 16x16 multiplier over the neurons in turn,
// each through the bias, MAC, drain, post and emit states, paced by the
// single MAC and the single weight memory read port.
// While the back part evaluates, the front keeps accepting words until the
// queue is full. A receiver stall holds the result register; the back part
// waits before overwriting it, so nothing is lost.
// Reset clears control state and loads mode 0, 64 inputs, 16 neurons;
// the stores are undefined until written and need no clearing pass.
// Config writes go on i_cfg_we with i_cfg_idx and i_cfg_data, only idle.
`include "dense_layer_with_activation_macros.svh"
module dense_layer_with_activation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dla_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output dla_pkg::t_out_word o_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [6:0]         i_cfg_data
);
    logic [1:0] r_mode;
    logic [6:0] r_nin;
    logic [4:0] r_nneu;
    logic [5:0] last_idx;
    logic [3:0] last_neu;

    // counts clamp to 1..max, so zero acts as one
    always_comb begin
        if (r_nin == '0)        last_idx = 6'd0;
        else if (r_nin > 7'd64) last_idx = 6'd63;
        else                    last_idx = 6'(r_nin - 7'd1);
        if (r_nneu == '0)        last_neu = 4'd0;
        else if (r_nneu > 5'd16) last_neu = 4'd15;
        else                     last_neu = 4'(r_nneu - 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
            r_nin  <= 7'd64;
            r_nneu <= 5'd16;
        end else if (i_cfg_we) begin
            case (dla_pkg::t_cfg_idx'(i_cfg_idx))
                dla_pkg::CFG_MODE:    r_mode <= i_cfg_data[1:0];
                dla_pkg::CFG_INPUTS:  r_nin  <= i_cfg_data;
                dla_pkg::CFG_NEURONS: r_nneu <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic push, full, empty, pop, busy;
    dla_pkg::t_cmd fcmd, qcmd;

    dla_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_word(i_data), .i_last_idx(last_idx), .o_push(push), .o_cmd(fcmd),
        .i_full(full)
    );

    dla_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(fcmd),
        .o_full(full), .o_empty(empty), .i_pop(pop), .o_cmd(qcmd)
    );

    dla_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_cmd(qcmd), .o_pop(pop),
        .i_mode(r_mode), .i_last_idx(last_idx), .i_last_neu(last_neu),
        .o_valid(o_valid), .i_ready(i_ready), .o_word(o_data), .o_busy(busy)
    );

    `DLA_ASSERT(a_no_pop_empty, i_clk, i_rst_n, pop |-> !empty, "pop from empty queue")
    `DLA_ASSERT(a_no_push_full, i_clk, i_rst_n, push |-> !full, "push into full queue")
    `DLA_ASSERT(a_out_busy, i_clk, i_rst_n, o_valid |-> busy, "result while idle")
endmodule
